[sv/lzbd_pkg.sv]
// shared types and constants of the lz back-reference byte decompressor
package lzbd_pkg;

   localparam int HISTORY_DEPTH_DEF = 256;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 7;
   localparam int DIST_W  = 9;
   localparam int VCNT_W  = 2;

   // top bit of a control byte selects a copy, the rest is the count
   localparam int COPY_BIT = 7;

   // distance used when the offset byte is zero
   localparam logic [DIST_W-1:0] DIST_FULL = 9'd256;

   localparam logic [VCNT_W-1:0] VCNT_NONE = 2'd0;
   localparam logic [VCNT_W-1:0] VCNT_ONE  = 2'd1;
   localparam logic [VCNT_W-1:0] VCNT_TWO  = 2'd2;

   typedef struct packed {
      logic ld_count;
      logic dec_count;
      logic ld_dist;
      logic emit_lit;
      logic emit_end;
      logic rd_issue;
      logic wr_copy;
      logic keep_first;
      logic emit_copy;
   } cmd_type;

   typedef struct packed {
      logic byte_zero;
      logic byte_copy;
      logic count_zero;
      logic count_one;
      logic half;
      logic out_free;
   } status_type;

endpackage

[sv/lz_backref_byte_decompressor.sv]
// top level of the lz back-reference byte decompressor
// Takes one compressed byte per beat. Control bytes, offset bytes and literal
// bytes are each taken when offered, so a literal run passes one byte per
// cycle; a control or literal beat is held off only while the result register
// is full. A back reference holds the input from its offset byte until its
// last byte is written, longer on result stalls: the history ring is one ram
// with a registered read, and each copied byte is read and then written so
// that overlapping copies see bytes written just before. Copied bytes leave
// two per result beat, an odd last one alone. The ring needs no clearing pass
// after reset: a fill flag makes slots unwritten since reset read as zero.
module lz_backref_byte_decompressor #(
   parameter int HISTORY_DEPTH = lzbd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lzbd_pkg::BYTE_W-1:0]   req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lzbd_pkg::BYTE_W-1:0]   rsp_byte_first,
   output logic [lzbd_pkg::BYTE_W-1:0]   rsp_byte_second,
   output logic [lzbd_pkg::VCNT_W-1:0]   rsp_valid_count,
   output logic                          rsp_run_last,
   output logic                          rsp_stream_end
);

   lzbd_pkg::cmd_type    cmd;
   lzbd_pkg::status_type sts;

   lzbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lzbd_dpath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_in_byte     (req_in_byte),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_byte_first  (rsp_byte_first),
      .rsp_byte_second (rsp_byte_second),
      .rsp_valid_count (rsp_valid_count),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_end  (rsp_stream_end),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

[sv/lzbd_ram.sv]
// generic single-write, single-read ram with registered read data
module lzbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/lzbd_ctrl.sv]
// parser and copy sequencer state machine
module lzbd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lzbd_pkg::status_type sts,
   output lzbd_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_CTRL = 3'd0;
   localparam logic [2:0] S_LIT  = 3'd1;
   localparam logic [2:0] S_OFF  = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_WR   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   always_comb begin
      unique case (state_ff)
         S_CTRL, S_LIT: req_stall = !sts.out_free;
         S_OFF:         req_stall = 1'b0;
         default:       req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CTRL: begin
            if (accept) begin
               if (sts.byte_zero) begin
                  cmd.emit_end = 1'b1;
               end else begin
                  cmd.ld_count = 1'b1;
                  state_in     = sts.byte_copy ? S_OFF : S_LIT;
               end
            end
         end
         S_LIT: begin
            if (accept) begin
               cmd.emit_lit  = 1'b1;
               cmd.dec_count = 1'b1;
               if (sts.count_one) begin
                  state_in = S_CTRL;
               end
            end
         end
         S_OFF: begin
            if (accept) begin
               cmd.ld_dist = 1'b1;
               state_in    = sts.count_zero ? S_CTRL : S_RD;
            end
         end
         S_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_WR;
         end
         S_WR: begin
            if (sts.half || sts.count_one) begin
               // a full pair or the run end goes out as one beat
               if (sts.out_free) begin
                  cmd.wr_copy   = 1'b1;
                  cmd.dec_count = 1'b1;
                  cmd.emit_copy = 1'b1;
                  state_in      = sts.count_one ? S_CTRL : S_RD;
               end
            end else begin
               cmd.wr_copy    = 1'b1;
               cmd.dec_count  = 1'b1;
               cmd.keep_first = 1'b1;
               state_in       = S_RD;
            end
         end
         default: begin
            state_in = S_CTRL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CTRL;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/lzbd_dpath.sv]
// history ring, pointers, counters and result register
module lzbd_dpath #(
   parameter int HISTORY_DEPTH = lzbd_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lzbd_pkg::BYTE_W-1:0]   req_in_byte,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [lzbd_pkg::BYTE_W-1:0]   rsp_byte_first,
   output logic [lzbd_pkg::BYTE_W-1:0]   rsp_byte_second,
   output logic [lzbd_pkg::VCNT_W-1:0]   rsp_valid_count,
   output logic                          rsp_run_last,
   output logic                          rsp_stream_end,
   input  lzbd_pkg::cmd_type             cmd,
   output lzbd_pkg::status_type          sts
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
   localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);

   logic [AW-1:0]                   wp_ff, wp_in;
   logic                            full_ff, full_in;
   logic [lzbd_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [lzbd_pkg::DIST_W-1:0]     dist_ff, dist_in;
   logic                            half_ff, half_in;
   logic [lzbd_pkg::BYTE_W-1:0]     pair_ff, pair_in;
   logic                            rd_valid_ff, rd_valid_in;
   logic                            out_valid_ff, out_valid_in;
   logic [lzbd_pkg::BYTE_W-1:0]     first_ff, first_in;
   logic [lzbd_pkg::BYTE_W-1:0]     second_ff, second_in;
   logic [lzbd_pkg::VCNT_W-1:0]     vcnt_ff, vcnt_in;
   logic                            last_ff, last_in;
   logic                            end_ff, end_in;

   logic [AW:0]                     wp_ext;
   logic [AW:0]                     dist_ext;
   logic                            no_wrap;
   logic [AW:0]                     rd_idx;
   logic [AW-1:0]                   rd_addr;
   logic                            wr_en;
   logic [lzbd_pkg::BYTE_W-1:0]     wr_data;
   logic [lzbd_pkg::BYTE_W-1:0]     ram_q;
   logic [lzbd_pkg::BYTE_W-1:0]     rd_byte;
   logic                            out_free;

   // ring slot offset bytes back, slots never written read as zero
   assign wp_ext   = {1'b0, wp_ff};
   assign dist_ext = (AW+1)'(dist_ff);
   assign no_wrap  = wp_ext >= dist_ext;
   assign rd_idx   = no_wrap ? (wp_ext - dist_ext) : (wp_ext + DEPTH_EXT - dist_ext);
   assign rd_addr  = rd_idx[AW-1:0];

   assign rd_byte  = rd_valid_ff ? ram_q : '0;
   assign wr_en    = cmd.emit_lit || cmd.wr_copy;
   assign wr_data  = cmd.emit_lit ? req_in_byte : rd_byte;
   assign out_free = !out_valid_ff || !rsp_stall;

   lzbd_ram #(
      .WIDTH (lzbd_pkg::BYTE_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      wp_in       = wp_ff;
      full_in     = full_ff;
      count_in    = count_ff;
      dist_in     = dist_ff;
      half_in     = half_ff;
      pair_in     = pair_ff;
      rd_valid_in = rd_valid_ff;
      if (wr_en) begin
         if (wp_ff == LAST_ADDR) begin
            wp_in   = '0;
            full_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
      if (cmd.ld_count) begin
         count_in = req_in_byte[lzbd_pkg::COUNT_W-1:0];
      end else if (cmd.dec_count) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.ld_dist) begin
         dist_in = (req_in_byte == '0) ? lzbd_pkg::DIST_FULL
                                       : lzbd_pkg::DIST_W'(req_in_byte);
      end
      if (cmd.keep_first) begin
         half_in = 1'b1;
         pair_in = rd_byte;
      end else if (cmd.emit_copy) begin
         half_in = 1'b0;
      end
      if (cmd.rd_issue) begin
         rd_valid_in = full_ff || no_wrap;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      first_in     = first_ff;
      second_in    = second_ff;
      vcnt_in      = vcnt_ff;
      last_in      = last_ff;
      end_in       = end_ff;
      if (cmd.emit_lit) begin
         out_valid_in = 1'b1;
         first_in     = req_in_byte;
         second_in    = '0;
         vcnt_in      = lzbd_pkg::VCNT_ONE;
         last_in      = 1'b1;
         end_in       = 1'b0;
      end else if (cmd.emit_end) begin
         out_valid_in = 1'b1;
         first_in     = '0;
         second_in    = '0;
         vcnt_in      = lzbd_pkg::VCNT_NONE;
         last_in      = 1'b1;
         end_in       = 1'b1;
      end else if (cmd.emit_copy) begin
         out_valid_in = 1'b1;
         first_in     = half_ff ? pair_ff : rd_byte;
         second_in    = half_ff ? rd_byte : '0;
         vcnt_in      = half_ff ? lzbd_pkg::VCNT_TWO : lzbd_pkg::VCNT_ONE;
         last_in      = (count_ff == 7'd1);
         end_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         full_ff      <= 1'b0;
         count_ff     <= '0;
         half_ff      <= 1'b0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         full_ff      <= full_in;
         count_ff     <= count_in;
         half_ff      <= half_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff   <= dist_in;
      pair_ff   <= pair_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      vcnt_ff   <= vcnt_in;
      last_ff   <= last_in;
      end_ff    <= end_in;
   end

   assign sts.byte_zero  = (req_in_byte == '0);
   assign sts.byte_copy  = req_in_byte[lzbd_pkg::COPY_BIT];
   assign sts.count_zero = (count_ff == '0);
   assign sts.count_one  = (count_ff == 7'd1);
   assign sts.half       = half_ff;
   assign sts.out_free   = out_free;

   assign rsp_valid       = out_valid_ff;
   assign rsp_byte_first  = first_ff;
   assign rsp_byte_second = second_ff;
   assign rsp_valid_count = vcnt_ff;
   assign rsp_run_last    = last_ff;
   assign rsp_stream_end  = end_ff;

endmodule

[tb/sv/testbench.sv]
// testbench of the lz back-reference byte decompressor: directed and random streams checked against a predictor
module testbench;
   import lzbd_pkg::*;

   typedef enum logic [1:0] {
      PH_CONTROL,
      PH_LITERAL,
      PH_OFFSET
   } parse_phase_t;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_first;
      logic [BYTE_W-1:0] byte_second;
      logic [VCNT_W-1:0] valid_count;
      logic              run_last;
      logic              stream_end;
   } out_beat_t;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_in_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic [BYTE_W-1:0]   rsp_byte_first;
   logic [BYTE_W-1:0]   rsp_byte_second;
   logic [VCNT_W-1:0]   rsp_valid_count;
   logic                rsp_run_last;
   logic                rsp_stream_end;

   logic                steady      = 1'b0;
   int                  errors      = 0;
   int                  bytes_sent  = 0;

   // predictor state
   logic [BYTE_W-1:0]   history [256];
   logic [BYTE_W-1:0]   hist_wr_ptr = '0;
   parse_phase_t        phase       = PH_CONTROL;
   logic [COUNT_W-1:0]  run_left    = '0;
   out_beat_t           decoded_q[$];

   lz_backref_byte_decompressor i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_byte_first  (rsp_byte_first),
      .rsp_byte_second (rsp_byte_second),
      .rsp_valid_count (rsp_valid_count),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_end  (rsp_stream_end)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < 256; i++) begin
         history[i] = '0;
      end
   end

   function automatic void report_error(input string msg);
      errors++;
      if (errors <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function automatic void decode_byte(input logic [BYTE_W-1:0] b);
      logic [COUNT_W-1:0] left;
      logic [BYTE_W-1:0]  src;
      logic [BYTE_W-1:0]  pair [2];
      int                 got;
      case (phase)
         PH_LITERAL: begin
            history[hist_wr_ptr] = b;
            hist_wr_ptr++;
            decoded_q.push_back(out_beat_t'{b, 8'h00, VCNT_ONE, 1'b1, 1'b0});
            run_left--;
            if (run_left == 0) begin
               phase = PH_CONTROL;
            end
         end
         PH_OFFSET: begin
            left     = run_left;
            phase    = PH_CONTROL;
            run_left = '0;
            while (left != 0) begin
               pair[0] = '0;
               pair[1] = '0;
               got     = 0;
               while (got < 2 && left != 0) begin
                  // offset zero wraps to the slot 256 back
                  src = hist_wr_ptr - b;
                  pair[got] = history[src];
                  history[hist_wr_ptr] = pair[got];
                  hist_wr_ptr++;
                  got++;
                  left--;
               end
               decoded_q.push_back(out_beat_t'{pair[0], pair[1],
                  (got == 2) ? VCNT_TWO : VCNT_ONE, left == 0, 1'b0});
            end
         end
         default: begin
            if (b == 0) begin
               run_left = '0;
               decoded_q.push_back(out_beat_t'{8'h00, 8'h00, VCNT_NONE, 1'b1, 1'b1});
            end else begin
               run_left = b[COUNT_W-1:0];
               phase    = b[COPY_BIT] ? PH_OFFSET : PH_LITERAL;
            end
         end
      endcase
   endfunction

   // result side: check each beat, then pick the next stall
   always @(posedge clock) begin : result_check
      out_beat_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            report_error($sformatf("unexpected beat: first %h second %h count %0d last %b end %b",
               rsp_byte_first, rsp_byte_second, rsp_valid_count, rsp_run_last,
               rsp_stream_end));
         end else begin
            want = decoded_q.pop_front();
            if (rsp_byte_first !== want.byte_first || rsp_byte_second !== want.byte_second ||
                rsp_valid_count !== want.valid_count || rsp_run_last !== want.run_last ||
                rsp_stream_end !== want.stream_end) begin
               report_error($sformatf(
                  "mismatch: exp %h %h %0d %b %b, got %h %h %0d %b %b",
                  want.byte_first, want.byte_second, want.valid_count, want.run_last,
                  want.stream_end, rsp_byte_first, rsp_byte_second, rsp_valid_count,
                  rsp_run_last, rsp_stream_end));
            end
         end
      end
      rsp_stall <= !steady && ($urandom_range(99) < 34);
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while (!steady && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      decode_byte(b);
      bytes_sent++;
   endtask

   task automatic send_literal_run(input int unsigned n);
      send_byte(BYTE_W'(n));
      for (int i = 0; i < n; i++) begin
         send_byte(BYTE_W'($urandom_range(255)));
      end
   endtask

   task automatic send_copy(input int unsigned n, input logic [BYTE_W-1:0] offset);
      send_byte({1'b1, COUNT_W'(n)});
      send_byte(offset);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_terminator();
      send_byte(8'h00);
   endtask

   task automatic test_literal_extremes();
      send_byte(8'h03);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h5a);
   endtask

   task automatic test_copy_cases();
      send_copy(2, 8'h03);
      // odd count with overlap
      send_copy(3, 8'h01);
      // zero count still eats the offset
      send_copy(0, 8'h05);
      send_copy(5, 8'h00);
      wait_drained();
      send_copy(127, 8'h02);
      send_byte(8'h00);
   endtask

   task automatic test_back_to_back();
      steady <= 1'b1;
      send_literal_run(60);
      send_copy(16, 8'h07);
      send_copy(1, 8'h01);
      send_literal_run(3);
      wait_drained();
      steady <= 1'b0;
   endtask

   task automatic test_random_streams();
      int unsigned pick;
      int unsigned n;
      bit          paused = 1'b0;
      while (bytes_sent < 500) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 8);
            send_literal_run(n);
         end else if (pick < 88) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12);
            send_copy(n, ($urandom_range(1) == 0) ? BYTE_W'($urandom_range(255))
                                                  : BYTE_W'($urandom_range(0, 16)));
         end else if (pick < 94) begin
            send_byte(8'h00);
         end else begin
            send_byte(BYTE_W'($urandom_range(255)));
         end
         if (!paused && bytes_sent >= 250) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_terminator();
      test_literal_extremes();
      test_copy_cases();
      test_back_to_back();
      test_random_streams();
      wait_drained();
      repeat (40) @(posedge clock);
      if (errors == 0 && decoded_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4800000;
      $display("Verification failed");
      $finish;
   end

endmodule
